// ===== sv/pmr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmr_pkg
// Shared types, register offsets and a helper function for the power
// management register block.
// ----------------------------------------------------------------------------
package pmr_pkg;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } pmr_op_t;

    localparam int OFS_W  = 9;
    localparam int DATA_W = 24;
    localparam int DOM_W  = 23;

    localparam logic [OFS_W-1:0] OFS_RSTC  = 9'h01c;
    localparam logic [OFS_W-1:0] OFS_RSTS  = 9'h020;
    localparam logic [OFS_W-1:0] OFS_WDOG  = 9'h024;
    localparam logic [OFS_W-1:0] OFS_USB   = 9'h05c;
    localparam logic [OFS_W-1:0] OFS_IMAGE = 9'h108;
    localparam logic [OFS_W-1:0] OFS_PROC  = 9'h110;

    localparam logic [7:0]        PW_KEY         = 8'h5a;
    localparam logic [11:0]       RSTS_HALT_CODE = 12'h555;
    localparam int                RSTC_GO_BIT    = 5;

    localparam logic [DATA_W-1:0] RSTC_RESET  = 24'h000102;
    localparam logic [DATA_W-1:0] RSTS_RESET  = 24'h001000;
    localparam logic [DOM_W-1:0]  IMAGE_RESET = 23'h001000;

    localparam logic [DOM_W-1:0]  IMAGE_WRITABLE = 23'h7f11ed;
    localparam logic [DOM_W-1:0]  PROC_WRITABLE  = 23'h7f106d;

    // one bus access
    typedef struct packed {
        pmr_op_t            op;
        logic [OFS_W-1:0]   offset;
        logic [31:0]        write_data;
    } pmr_req_t;

    // result of one access
    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               bad_password;
        logic               unknown_offset;
        logic               reset_request;
        logic               shutdown_request;
        logic               arm_power;
        logic               arm_power_changed;
    } pmr_rsp_t;

    // mask writable bits, then complete the power handshake at once
    function automatic logic [DOM_W-1:0] finish_domain(
        input logic [DOM_W-1:0] req,
        input logic [DOM_W-1:0] writable
    );
        logic [DOM_W-1:0] v;
        v = req & writable;
        if (v[0]) begin
            v[1] = 1'b1;               // power ok
        end
        if (v[0] && v[2] && v[3]) begin
            v[4] = 1'b1;               // memory repair done
        end
        return v;
    endfunction

endpackage
`default_nettype wire

// ===== sv/pmr_regfile.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pmr_regfile
// Register state and access decode: one access is decoded and applied per
// step; the response is combinational and registered by the caller.
// ----------------------------------------------------------------------------
module pmr_regfile
    import pmr_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire pmr_req_t req,
    output pmr_rsp_t      rsp
);

    logic [DATA_W-1:0] reset_control_reg,  reset_control_next;
    logic [DATA_W-1:0] reset_status_reg,   reset_status_next;
    logic [DATA_W-1:0] watchdog_value_reg, watchdog_value_next;
    logic              usb_enable_reg,     usb_enable_next;
    logic [DOM_W-1:0]  image_domain_reg,   image_domain_next;
    logic [DOM_W-1:0]  proc_domain_reg,    proc_domain_next;
    logic              proc_powered_reg,   proc_powered_next;

    logic [DATA_W-1:0] wval;
    logic              pw_ok;

    assign wval  = req.write_data[DATA_W-1:0];
    assign pw_ok = (req.write_data[31:24] == PW_KEY);

    always_comb begin
        reset_control_next  = reset_control_reg;
        reset_status_next   = reset_status_reg;
        watchdog_value_next = watchdog_value_reg;
        usb_enable_next     = usb_enable_reg;
        image_domain_next   = image_domain_reg;
        proc_domain_next    = proc_domain_reg;
        proc_powered_next   = proc_powered_reg;

        rsp = '0;

        case (req.offset)
            OFS_RSTC, OFS_RSTS, OFS_WDOG, OFS_USB, OFS_IMAGE, OFS_PROC:
                rsp.unknown_offset = 1'b0;
            default:
                rsp.unknown_offset = 1'b1;
        endcase

        if (req.op == OP_READ) begin
            case (req.offset)
                OFS_RSTC:  rsp.read_data = reset_control_reg;
                OFS_RSTS:  rsp.read_data = reset_status_reg;
                OFS_WDOG:  rsp.read_data = watchdog_value_reg;
                OFS_USB:   rsp.read_data = {{(DATA_W-1){1'b0}}, usb_enable_reg};
                OFS_IMAGE: rsp.read_data = {1'b0, image_domain_reg};
                OFS_PROC:  rsp.read_data = {1'b0, proc_domain_reg};
                default:   rsp.read_data = '0;
            endcase
        end else if (!pw_ok) begin
            rsp.bad_password = 1'b1;
        end else begin
            case (req.offset)
                OFS_RSTC: begin
                    reset_control_next = wval;
                    if (wval[RSTC_GO_BIT]) begin
                        if (reset_status_reg[11:0] == RSTS_HALT_CODE) begin
                            rsp.shutdown_request = 1'b1;
                        end else begin
                            rsp.reset_request = 1'b1;
                        end
                    end
                end
                OFS_RSTS:  reset_status_next   = wval;
                OFS_WDOG:  watchdog_value_next = wval;
                OFS_USB:   usb_enable_next     = wval[0];
                OFS_IMAGE: image_domain_next   =
                               finish_domain(wval[DOM_W-1:0], IMAGE_WRITABLE);
                OFS_PROC: begin
                    proc_domain_next  = finish_domain(wval[DOM_W-1:0], PROC_WRITABLE);
                    proc_powered_next = &proc_domain_next[6:0];
                end
                default: ;
            endcase
        end

        rsp.arm_power         = proc_powered_next;
        rsp.arm_power_changed = (proc_powered_next != proc_powered_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reset_control_reg  <= RSTC_RESET;
            reset_status_reg   <= RSTS_RESET;
            watchdog_value_reg <= '0;
            usb_enable_reg     <= 1'b0;
            image_domain_reg   <= IMAGE_RESET;
            proc_domain_reg    <= '0;
            proc_powered_reg   <= 1'b0;
        end else if (step) begin
            reset_control_reg  <= reset_control_next;
            reset_status_reg   <= reset_status_next;
            watchdog_value_reg <= watchdog_value_next;
            usb_enable_reg     <= usb_enable_next;
            image_domain_reg   <= image_domain_next;
            proc_domain_reg    <= proc_domain_next;
            proc_powered_reg   <= proc_powered_next;
        end
    end

    // never both pulses on one transaction
    a_one_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        step |-> !(rsp.reset_request && rsp.shutdown_request))
        else $error("reset and shutdown requested together");

    // a rejected write leaves every register alone
    a_bad_pw_no_change: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && rsp.bad_password) |=> ($stable(reset_control_reg)
            && $stable(reset_status_reg) && $stable(watchdog_value_reg)
            && $stable(usb_enable_reg) && $stable(image_domain_reg)
            && $stable(proc_domain_reg) && $stable(proc_powered_reg)))
        else $error("register changed on bad password write");

    // power-ok always follows power-up in both domains
    a_pow_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_domain_reg[1] == proc_domain_reg[0])
        && (image_domain_reg[1] == image_domain_reg[0]))
        else $error("domain power-ok out of step with power-up");

    // powered level tracks the processor domain contents
    a_powered: assert property (@(posedge aclk) disable iff (!aresetn)
        proc_powered_reg == (&proc_domain_reg[6:0]))
        else $error("proc_powered disagrees with proc_domain");

endmodule
`default_nettype wire

// ===== sv/power_mgmt_register_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// power_mgmt_register_block
// Password-protected power-management registers behind a valid/ready access
// channel with one response per access.
// ----------------------------------------------------------------------------
// Each transaction on s_ is a read or write of one register with 24-bit read
// data; writes need 0x5a in write_data[31:24] or are dropped and flagged. The
// block takes one transaction per cycle while m_ready does not stall it: an
// input register holds the access, the decode and register update happen as
// it moves into the output register, where the response sits until m_ready
// takes it; a stall on m_ready backs up through both stages one slot at a
// time.
// ----------------------------------------------------------------------------
module power_mgmt_register_block
    import pmr_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,

    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic              s_op,
    input  wire logic [OFS_W-1:0]  s_offset,
    input  wire logic [31:0]       s_write_data,

    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic [DATA_W-1:0]      m_read_data,
    output logic                   m_bad_password,
    output logic                   m_unknown_offset,
    output logic                   m_reset_request,
    output logic                   m_shutdown_request,
    output logic                   m_arm_power,
    output logic                   m_arm_power_changed
);

    logic     in_valid_reg;
    pmr_req_t in_req_reg;
    logic     out_valid_reg;
    pmr_rsp_t out_rsp_reg;
    pmr_rsp_t rsp;
    logic     advance;
    logic     step;

    assign advance = !out_valid_reg || m_ready;
    assign step    = in_valid_reg && advance;
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_req_reg.op         <= pmr_op_t'(s_op);
            in_req_reg.offset     <= s_offset;
            in_req_reg.write_data <= s_write_data;
        end
        if (step) begin
            out_rsp_reg <= rsp;
        end
    end

    pmr_regfile u_regfile (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .req     (in_req_reg),
        .rsp     (rsp)
    );

    assign m_valid             = out_valid_reg;
    assign m_read_data         = out_rsp_reg.read_data;
    assign m_bad_password      = out_rsp_reg.bad_password;
    assign m_unknown_offset    = out_rsp_reg.unknown_offset;
    assign m_reset_request     = out_rsp_reg.reset_request;
    assign m_shutdown_request  = out_rsp_reg.shutdown_request;
    assign m_arm_power         = out_rsp_reg.arm_power;
    assign m_arm_power_changed = out_rsp_reg.arm_power_changed;

endmodule
`default_nettype wire
